>>> sv/assert_macros.svh
// assertion helpers, compiled out for synthesis
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define SRE_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define SRE_ASSERT_NEVER(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(prop)) else $error(msg);
`else
`define SRE_ASSERT(lbl, clk, rst_n, prop, msg)
`define SRE_ASSERT_NEVER(lbl, clk, rst_n, prop, msg)
`endif
`endif

>>> sv/sre_pkg.sv
package sre_pkg;

  localparam int unsigned MaxClasses      = 16;
  localparam int unsigned ExpTableSize    = 256;
  localparam int unsigned Log2eQ15        = 47274;
  localparam longint unsigned Ln2Q32      = 64'd2977044472;
  localparam int unsigned SeriesTerms     = 20;
  localparam logic [4:0]  ClassCountReset = 5'd10;
  localparam logic [1:0]  AddrClassCount  = 2'd0;

  typedef struct packed {
    logic              command;
    logic signed [15:0] element_value;
  } in_word_t;

  typedef struct packed {
    logic signed [16:0] result_value;
    logic [3:0]         class_index;
    logic               row_last;
  } out_word_t;

  // 2^(-k/size) in q1.16 from the alternating series of exp(-y), y in q32
  function automatic logic [16:0] exp_series(input logic [63:0] y);
    logic [63:0] term;
    logic [63:0] acc;
    term = 64'd1 << 32;
    acc  = term;
    for (int n = 1; n <= SeriesTerms; n++) begin
      term = ((term * y) >> 32) / 64'(n);
      if ((n & 1) != 0) begin
        acc = acc - term;
      end else begin
        acc = acc + term;
      end
    end
    return 17'((acc + 64'd32768) >> 16);
  endfunction

endpackage

>>> sv/sre_ram.sv
module sre_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

>>> sv/sre_exp.sv
module sre_exp #(
  parameter int unsigned TabSize = sre_pkg::ExpTableSize
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic signed [15:0] x_i,
  input  logic signed [15:0] max_i,
  output logic               done_o,
  output logic [16:0]        e_o
);

  // table size is a power of two, so the split of t is a shift and a mask
  localparam int unsigned TabBits = $clog2(TabSize);

  logic [16:0] tab [TabSize];

  for (genvar g = 0; g < TabSize; g++) begin : g_tab
    localparam logic [63:0] Y = (64'(g) * 64'(sre_pkg::Ln2Q32)) / 64'(TabSize);
    localparam logic [16:0] V = sre_pkg::exp_series(Y);
    assign tab[g] = V;
  end

  logic               s1_q;
  logic [31:0]        prod_q;
  logic               done_q;
  logic [16:0]        e_q;
  logic [16:0]        diff;
  logic [32+TabBits:0] scaled;
  logic [9+TabBits:0] t;
  logic [9:0]         ip;
  logic [TabBits-1:0] k;
  logic [16:0]        v;
  logic [17:0]        half;
  logic [16:0]        e_d;

  assign diff = 17'(max_i) - 17'(x_i);

  always_comb begin
    scaled = ({1'b0, prod_q} << TabBits) + (33'(1) << 22);
    t      = (10 + TabBits)'(scaled >> 23);
    ip     = 10'(t >> TabBits);
    k      = t[TabBits-1:0];
    v      = tab[k];
    half   = 18'(1) << (ip - 10'd1);
    if (ip >= 10'd17) begin
      e_d = '0;
    end else if (ip == 10'd0) begin
      e_d = v;
    end else begin
      e_d = 17'((18'(v) + half) >> ip);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_q   <= 1'b0;
      done_q <= 1'b0;
    end else begin
      s1_q   <= start_i;
      done_q <= s1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      prod_q <= 32'(diff[15:0]) * 32'(sre_pkg::Log2eQ15);
    end
    if (s1_q) begin
      e_q <= e_d;
    end
  end

  assign done_o = done_q;
  assign e_o    = e_q;

endmodule

>>> sv/sre_div.sv
module sre_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [31:0] num_i,
  input  logic [20:0] den_i,
  output logic        done_o,
  output logic [16:0] quo_o
);

  // restoring divider, one quotient bit a cycle; quotient fits 17 bits
  logic [21:0] rem_q;
  logic [16:0] quo_q;
  logic [20:0] den_q;
  logic [4:0]  cnt_q;
  logic        busy_q;
  logic        done_q;
  logic [21:0] trial;
  logic        ge;

  assign trial = {rem_q[20:0], quo_q[16]};
  assign ge    = trial >= {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= 5'd17;
      end else if (busy_q) begin
        cnt_q <= cnt_q - 5'd1;
        if (cnt_q == 5'd1) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= 22'(num_i >> 17);
      quo_q <= num_i[16:0];
      den_q <= den_i;
    end else if (busy_q) begin
      rem_q <= ge ? (trial - {1'b0, den_q}) : trial;
      quo_q <= {quo_q[15:0], ge};
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

>>> sv/softmax_row_engine_unit.sv
// softmax row engine: softmax forward and backward over one row of classes
// input channel (in_valid_i / in_stall_o / in_word_i): one class element a word,
// a row is class_count words, clamped to 1..MaxClasses; the first word's command
// picks forward (0, q8.8 logits) or backward (1, q8.8 output gradients).
// output channel (out_valid_o / out_stall_i / out_word_o): after the last word
// of a row, one result word per class in class order, row_last on the final one.
// loading accepts one word per cycle. a forward row then sums the class
// exponentials, then divides each by the sum in the 17-step serial divider.
// a backward row forms the dot product of cached probabilities and gradients,
// then makes each result with the 16-step serial multiplier. in_stall_o is
// high from the last word of a row until its last result is taken. a stalled
// result holds and the sequencer waits on it. class_count is written over the
// apb port (byte address 0), only while idle: a rule for the user, not enforced.
// reset: class_count 10, no row in progress, cached probabilities read as zero.
`include "assert_macros.svh"

module softmax_row_engine_unit #(
  parameter int unsigned MaxClasses   = sre_pkg::MaxClasses,
  parameter int unsigned ExpTableSize = sre_pkg::ExpTableSize
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  sre_pkg::in_word_t in_word_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output sre_pkg::out_word_t out_word_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [1:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  localparam int unsigned IdxW = $clog2(MaxClasses);
  localparam int unsigned CntW = IdxW + 1;

  typedef enum logic [3:0] {
    S_LOAD, S_SUM_RD, S_SUM_EXP, S_SUM_WAIT, S_DIV_RD, S_DIV_EXP, S_DIV_WAIT,
    S_DIV_RUN, S_DOT_RD, S_DOT_ACC, S_BW_RD, S_BW_SET, S_BW_MUL, S_BW_FIN, S_OUT
  } state_e;

  state_e               state_q, state_d;
  logic [4:0]           cc_q;
  logic [IdxW-1:0]      load_q, load_d;
  logic                 kind_q, kind_d;
  logic signed [15:0]   max_q, max_d;
  logic [20:0]          sum_q, sum_d;
  logic signed [37:0]   dot_q, dot_d;
  logic [IdxW-1:0]      idx_q, idx_d;
  logic [CntW-1:0]      m_q, m_d;
  logic [MaxClasses-1:0] pvalid_q, pvalid_d;
  logic signed [55:0]   acc_q, acc_d;
  logic signed [55:0]   mcand_q, mcand_d;
  logic [15:0]          mplier_q, mplier_d;
  logic [4:0]           mcnt_q, mcnt_d;
  logic                 out_valid_q, out_valid_d;
  sre_pkg::out_word_t   out_word_q, out_word_d;

  logic                 in_acc;
  logic [CntW-1:0]      n_eff;
  logic [CntW-1:0]      m_new;
  logic                 kind_eff;
  logic                 is_last;
  logic [15:0]          row_rdata;
  logic [15:0]          prob_rdata;
  logic [15:0]          pv;
  logic signed [15:0]   g;
  logic                 exp_start, exp_done;
  logic [16:0]          exp_val;
  logic                 div_start, div_done;
  logic [16:0]          quo;
  logic [31:0]          div_num;
  logic                 prob_we;
  logic signed [37:0]   d_val;
  logic signed [25:0]   r_full;

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cc_q <= sre_pkg::ClassCountReset;
    end else if (psel && penable && pwrite && paddr == sre_pkg::AddrClassCount) begin
      cc_q <= pwdata[4:0];
    end
  end

  assign prdata = (paddr == sre_pkg::AddrClassCount) ? 32'(cc_q) : '0;
  assign pready = 1'b1;

  always_comb begin
    if (cc_q == 5'd0) begin
      n_eff = CntW'(1);
    end else if (int'(cc_q) > MaxClasses) begin
      n_eff = CntW'(MaxClasses);
    end else begin
      n_eff = CntW'(cc_q);
    end
  end

  assign in_acc   = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != S_LOAD);
  assign m_new    = CntW'(load_q) + CntW'(1);
  assign kind_eff = (load_q == '0) ? in_word_i.command : kind_q;
  assign is_last  = (CntW'(idx_q) + CntW'(1)) == m_q;
  assign g        = signed'(row_rdata);
  assign pv       = pvalid_q[idx_q] ? prob_rdata : '0;
  assign div_num  = (32'(exp_val) << 15) + 32'(sum_q >> 1);
  assign d_val    = (38'(g) <<< 15) - dot_q;
  assign r_full   = 26'((acc_q + 56'sd536870912) >>> 30);

  sre_ram #(.Width(16), .Depth(MaxClasses)) u_row_ram (
    .clk_i   (clk_i),
    .we_i    (in_acc),
    .waddr_i (load_q),
    .wdata_i (in_word_i.element_value),
    .raddr_i (idx_q),
    .rdata_o (row_rdata)
  );

  sre_ram #(.Width(16), .Depth(MaxClasses)) u_prob_ram (
    .clk_i   (clk_i),
    .we_i    (prob_we),
    .waddr_i (idx_q),
    .wdata_i (quo[15:0]),
    .raddr_i (idx_q),
    .rdata_o (prob_rdata)
  );

  sre_exp #(.TabSize(ExpTableSize)) u_exp (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (exp_start),
    .x_i     (g),
    .max_i   (max_q),
    .done_o  (exp_done),
    .e_o     (exp_val)
  );

  sre_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (sum_q),
    .done_o  (div_done),
    .quo_o   (quo)
  );

  always_comb begin
    state_d     = state_q;
    load_d      = load_q;
    kind_d      = kind_q;
    max_d       = max_q;
    sum_d       = sum_q;
    dot_d       = dot_q;
    idx_d       = idx_q;
    m_d         = m_q;
    pvalid_d    = pvalid_q;
    acc_d       = acc_q;
    mcand_d     = mcand_q;
    mplier_d    = mplier_q;
    mcnt_d      = mcnt_q;
    out_valid_d = out_valid_q;
    out_word_d  = out_word_q;
    exp_start   = 1'b0;
    div_start   = 1'b0;
    prob_we     = 1'b0;
    case (state_q)
      S_LOAD: begin
        if (in_acc) begin
          kind_d = kind_eff;
          if (!kind_eff && (load_q == '0 || in_word_i.element_value > max_q)) begin
            max_d = in_word_i.element_value;
          end
          if (m_new < n_eff) begin
            load_d = IdxW'(m_new);
          end else begin
            load_d = '0;
            m_d    = m_new;
            idx_d  = '0;
            if (!kind_eff) begin
              sum_d   = '0;
              state_d = S_SUM_RD;
            end else begin
              dot_d   = '0;
              state_d = S_DOT_RD;
            end
          end
        end
      end
      S_SUM_RD:  state_d = S_SUM_EXP;
      S_SUM_EXP: begin
        exp_start = 1'b1;
        state_d   = S_SUM_WAIT;
      end
      S_SUM_WAIT: begin
        if (exp_done) begin
          sum_d = sum_q + 21'(exp_val);
          if (is_last) begin
            idx_d   = '0;
            state_d = S_DIV_RD;
          end else begin
            idx_d   = idx_q + IdxW'(1);
            state_d = S_SUM_RD;
          end
        end
      end
      S_DIV_RD:  state_d = S_DIV_EXP;
      S_DIV_EXP: begin
        exp_start = 1'b1;
        state_d   = S_DIV_WAIT;
      end
      S_DIV_WAIT: begin
        if (exp_done) begin
          div_start = 1'b1;
          state_d   = S_DIV_RUN;
        end
      end
      S_DIV_RUN: begin
        if (div_done) begin
          prob_we                 = 1'b1;
          pvalid_d[idx_q]         = 1'b1;
          out_word_d.result_value = signed'(quo);
          out_word_d.class_index  = 4'(idx_q);
          out_word_d.row_last     = is_last;
          out_valid_d             = 1'b1;
          state_d                 = S_OUT;
        end
      end
      S_DOT_RD:  state_d = S_DOT_ACC;
      S_DOT_ACC: begin
        dot_d = dot_q + 38'(signed'({1'b0, pv}) * g);
        if (is_last) begin
          idx_d   = '0;
          state_d = S_BW_RD;
        end else begin
          idx_d   = idx_q + IdxW'(1);
          state_d = S_DOT_RD;
        end
      end
      S_BW_RD:  state_d = S_BW_SET;
      S_BW_SET: begin
        acc_d    = '0;
        mcand_d  = 56'(d_val);
        mplier_d = pv;
        mcnt_d   = 5'd16;
        state_d  = S_BW_MUL;
      end
      S_BW_MUL: begin
        // shift-add multiply, one multiplier bit a cycle
        if (mplier_q[0]) begin
          acc_d = acc_q + mcand_q;
        end
        mcand_d  = mcand_q <<< 1;
        mplier_d = mplier_q >> 1;
        mcnt_d   = mcnt_q - 5'd1;
        if (mcnt_q == 5'd1) begin
          state_d = S_BW_FIN;
        end
      end
      S_BW_FIN: begin
        if (r_full > 26'sd32767) begin
          out_word_d.result_value = 17'sd32767;
        end else if (r_full < -26'sd32768) begin
          out_word_d.result_value = -17'sd32768;
        end else begin
          out_word_d.result_value = 17'(r_full);
        end
        out_word_d.class_index = 4'(idx_q);
        out_word_d.row_last    = is_last;
        out_valid_d            = 1'b1;
        state_d                = S_OUT;
      end
      S_OUT: begin
        if (!out_stall_i) begin
          out_valid_d = 1'b0;
          if (is_last) begin
            state_d = S_LOAD;
          end else begin
            idx_d   = idx_q + IdxW'(1);
            state_d = kind_q ? S_BW_RD : S_DIV_RD;
          end
        end
      end
      default: state_d = S_LOAD;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_LOAD;
      load_q      <= '0;
      kind_q      <= 1'b0;
      max_q       <= '0;
      sum_q       <= '0;
      dot_q       <= '0;
      idx_q       <= '0;
      m_q         <= '0;
      pvalid_q    <= '0;
      mcnt_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      load_q      <= load_d;
      kind_q      <= kind_d;
      max_q       <= max_d;
      sum_q       <= sum_d;
      dot_q       <= dot_d;
      idx_q       <= idx_d;
      m_q         <= m_d;
      pvalid_q    <= pvalid_d;
      mcnt_q      <= mcnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q      <= acc_d;
    mcand_q    <= mcand_d;
    mplier_q   <= mplier_d;
    out_word_q <= out_word_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

  `SRE_ASSERT(a_no_load_while_out, clk_i, rst_ni, out_valid_o |-> in_stall_o, "input taken while a result is pending")
  `SRE_ASSERT(a_sum_nonzero, clk_i, rst_ni, (state_q == S_DIV_RUN) |-> (sum_q != '0), "division by an empty exponential sum")
  `SRE_ASSERT(a_row_end, clk_i, rst_ni, (out_valid_o && !out_stall_i && out_word_o.row_last) |=> (!out_valid_o && !in_stall_o), "row end did not return to loading")

endmodule
